// ===== sv/lps_pkg.sv =====
// Shared constants and types for the LED pattern sequencer.
// Used by led_pattern_sequencer_core, lps_checker and tb_top; no dependencies.
package lps_pkg;

    // Pattern table size and derived widths
    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int POS_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths
    localparam int INDEX_W     = 6;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;

    // Request command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RUN     = 2'd0,
        CFG_REPEAT  = 2'd1,
        CFG_DIVIDER = 2'd2
    } cfg_reg_t;

endpackage

// ===== sv/lps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/led_pattern_sequencer_core.sv =====
// LED pattern sequencer: table writes and timer ticks in, pattern bytes out.
// A tick that emits shows its byte on led_value in the cycle after the request.
// One request per cycle while the output is not stalled; the result
// register and the table's registered read port allow this.
// Reset: asynchronous, clears registers, countdown, position and all table valid bits;
// unwritten entries read as zero, so no clearing pass is needed.
module led_pattern_sequencer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // Request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [lps_pkg::INDEX_W-1:0]       entry_index,
    input  logic [lps_pkg::BYTE_W-1:0]        entry_value,
    // Result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lps_pkg::BYTE_W-1:0]        led_value,
    // Configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lps_pkg::BYTE_W-1:0]        cfg_data
);

    // Configuration registers
    logic                         run_enable_reg;
    logic                         repeat_enable_reg;
    logic [lps_pkg::BYTE_W-1:0]   tick_divider_reg;

    // Playback state
    logic [lps_pkg::BYTE_W-1:0]   countdown_reg;
    logic [lps_pkg::BYTE_W-1:0]   countdown_next;
    logic [lps_pkg::POS_W-1:0]    position_reg;
    logic [lps_pkg::POS_W-1:0]    position_next;
    logic [lps_pkg::POS_W-1:0]    position_inc;

    // Table valid bits and read-side flags
    logic [lps_pkg::TABLE_DEPTH-1:0] entry_valid_reg;
    logic                            hit_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;

    logic                            accept;
    logic                            is_write;
    logic                            write_en;
    logic                            emit;
    logic [lps_pkg::ADDR_W-1:0]      waddr;
    logic [lps_pkg::ADDR_W-1:0]      raddr;
    logic [lps_pkg::BYTE_W-1:0]      rdata;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign is_write  = (command == lps_pkg::CMD_WRITE);

    // Table write
    assign waddr    = lps_pkg::ADDR_W'(entry_index);
    assign write_en = accept & is_write & (int'(entry_index) < lps_pkg::TABLE_DEPTH);
    assign raddr    = position_reg[lps_pkg::ADDR_W-1:0];
    assign position_inc = position_reg + lps_pkg::POS_W'(1);

    // Tick handling: count down, reload, emit, advance, wrap
    always_comb
    begin
        countdown_next = countdown_reg;
        position_next  = position_reg;
        emit           = 1'b0;
        if (accept && !is_write && run_enable_reg)
        begin
            if (countdown_reg == '0)
            begin
                countdown_next = tick_divider_reg;
                if (int'(position_reg) < lps_pkg::TABLE_DEPTH)
                begin
                    emit = 1'b1;
                    if ((int'(position_inc) >= lps_pkg::TABLE_DEPTH) && repeat_enable_reg)
                    begin
                        position_next = '0;
                    end
                    else
                    begin
                        position_next = position_inc;
                    end
                end
                else if (repeat_enable_reg)
                begin
                    position_next = '0;
                end
            end
            else
            begin
                countdown_next = countdown_reg - lps_pkg::BYTE_W'(1);
            end
        end
    end

    // Result register valid
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_stall)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_enable_reg    <= 1'b0;
            repeat_enable_reg <= 1'b0;
            tick_divider_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lps_pkg::cfg_reg_t'(cfg_index))
                lps_pkg::CFG_RUN:     run_enable_reg    <= cfg_data[0];
                lps_pkg::CFG_REPEAT:  repeat_enable_reg <= cfg_data[0];
                lps_pkg::CFG_DIVIDER: tick_divider_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Playback state and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            countdown_reg   <= '0;
            position_reg    <= '0;
            entry_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            countdown_reg <= countdown_next;
            position_reg  <= position_next;
            out_valid_reg <= out_valid_next;
            if (write_en)
            begin
                entry_valid_reg[waddr] <= 1'b1;
            end
            // capture whether the entry read holds written data
            if (emit)
            begin
                hit_reg <= entry_valid_reg[raddr];
            end
        end
    end

    // Pattern table
    lps_ram #(
        .WIDTH (lps_pkg::BYTE_W),
        .DEPTH (lps_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (write_en),
        .waddr (waddr),
        .wdata (entry_value),
        .re    (emit),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Never-written entries read as zero
    assign out_valid = out_valid_reg;
    assign led_value = hit_reg ? rdata : '0;

endmodule

// ===== sv/lps_checker.sv =====
// Port-level checks for led_pattern_sequencer_core, attached by bind.
// Depends on lps_pkg for widths and command codes.
module lps_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              command,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [lps_pkg::BYTE_W-1:0]        led_value,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(led_value))
        else $error("stalled result changed");

    // Request side only stalls behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("request stalled without a held result");

    // A table write never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (command == lps_pkg::CMD_WRITE) |=> !out_valid)
        else $error("table write produced a result");

    // A new result follows an accepted tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid && out_stall) |->
            $past(in_valid && !in_stall && (command == lps_pkg::CMD_TICK)))
        else $error("result without a tick request");

    // Configuration writes are never refused
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind led_pattern_sequencer_core lps_checker u_lps_checker (.*);

// ===== test/tb_top.sv =====
// Self-checking testbench for led_pattern_sequencer_core: table writes and ticks in,
// pattern bytes out, checked against a cycle-free model of the playback state.
// Depends on lps_pkg and the led_pattern_sequencer_core RTL only.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 1750;
    localparam int MAX_WAIT      = 13;
    localparam int DRAIN_CYCLES  = 4;
    localparam int WATCHDOG_MAX  = 1000;
    localparam int REPORT_CAP    = 100;

    // One request on the input channel, with the idle cycles that precede it
    typedef struct {
        logic                        command;
        logic [lps_pkg::INDEX_W-1:0] index;
        logic [lps_pkg::BYTE_W-1:0]  value;
        int                          gap;
    } lps_req_t;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          in_valid    = 1'b0;
    logic                          in_stall;
    logic                          command     = lps_pkg::CMD_TICK;
    logic [lps_pkg::INDEX_W-1:0]   entry_index = '0;
    logic [lps_pkg::BYTE_W-1:0]    entry_value = '0;
    logic                          out_valid;
    logic                          out_stall   = 1'b0;
    logic [lps_pkg::BYTE_W-1:0]    led_value;
    logic                          cfg_valid   = 1'b0;
    logic                          cfg_ready;
    logic [lps_pkg::CFG_IDX_W-1:0] cfg_index   = lps_pkg::CFG_RUN;
    logic [lps_pkg::BYTE_W-1:0]    cfg_data    = '0;

    // Playback model state
    logic [lps_pkg::BYTE_W-1:0]    pattern_mdl [lps_pkg::TABLE_DEPTH];
    logic [lps_pkg::BYTE_W-1:0]    countdown_mdl = '0;
    int                            position_mdl  = 0;
    logic                          run_mdl       = 1'b0;
    logic                          repeat_mdl    = 1'b0;
    logic [lps_pkg::BYTE_W-1:0]    divider_mdl   = '0;

    lps_req_t                      pending_q[$];
    logic [lps_pkg::BYTE_W-1:0]    led_expect_q[$];
    lps_req_t                      cur_req;
    int                            gap_left   = -1;
    int                            stall_left = 0;
    int                            idle_cycles = 0;
    int                            err_count  = 0;
    int                            n_pushed   = 0;
    bit                            burst      = 1'b0;

    led_pattern_sequencer_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .led_value   (led_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Idle cycles before a request or after a result; none during a burst phase
    function automatic int draw_wait();
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic report_mismatch(string msg);
        if (err_count < REPORT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // Advance the playback model by one accepted request
    function automatic void predict_led(lps_req_t r);
        if (r.command == lps_pkg::CMD_WRITE)
        begin
            if (int'(r.index) < lps_pkg::TABLE_DEPTH)
                pattern_mdl[r.index] = r.value;
        end
        else if (run_mdl)
        begin
            if (countdown_mdl == 0)
            begin
                countdown_mdl = divider_mdl;
                if (position_mdl < lps_pkg::TABLE_DEPTH)
                begin
                    led_expect_q.push_back(pattern_mdl[position_mdl]);
                    position_mdl++;
                end
                if (position_mdl >= lps_pkg::TABLE_DEPTH && repeat_mdl)
                    position_mdl = 0;
            end
            else
            begin
                countdown_mdl = countdown_mdl - 1'b1;
            end
        end
    endfunction

    task automatic push_req(logic cmd, logic [lps_pkg::INDEX_W-1:0] idx,
                            logic [lps_pkg::BYTE_W-1:0] val);
        lps_req_t r;
        r.command = cmd;
        r.index   = idx;
        r.value   = val;
        r.gap     = draw_wait();
        pending_q.push_back(r);
        n_pushed++;
    endtask

    // Register write; only called while nothing is in flight
    task automatic cfg_write(lps_pkg::cfg_reg_t idx, logic [lps_pkg::BYTE_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            lps_pkg::CFG_RUN:     run_mdl     = data[0];
            lps_pkg::CFG_REPEAT:  repeat_mdl  = data[0];
            lps_pkg::CFG_DIVIDER: divider_mdl = data;
            default:              ;
        endcase
    endtask

    // Wait until every request is taken and every expected byte has come out
    task automatic settle();
        do @(negedge clk);
        while (pending_q.size() != 0 || in_valid || led_expect_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = -1;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_led(cur_req);
            if (!in_valid || !in_stall)
            begin
                if (pending_q.size() != 0)
                begin
                    if (gap_left < 0)
                        gap_left = pending_q[0].gap;
                    if (gap_left > 0)
                    begin
                        gap_left--;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        cur_req = pending_q.pop_front();
                        gap_left = -1;
                        command     <= cur_req.command;
                        entry_index <= cur_req.index;
                        entry_value <= cur_req.value;
                        in_valid    <= 1'b1;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and output backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (led_expect_q.size() == 0)
                    report_mismatch($sformatf("led_value %02h with none expected", led_value));
                else
                begin
                    if (led_value !== led_expect_q[0])
                        report_mismatch($sformatf("led_value %02h, expected %02h",
                                                  led_value, led_expect_q[0]));
                    void'(led_expect_q.pop_front());
                end
                stall_left = draw_wait();
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    // Watchdog: too long without any handshake on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("[%0t] watchdog expired", $realtime);
                $display("led_pattern_sequencer_core regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int                         len;
        int                         tick_pct;
        logic                       run_v;
        logic                       rep_v;
        logic [lps_pkg::BYTE_W-1:0] div_v;

        for (int i = 0; i < lps_pkg::TABLE_DEPTH; i++)
            pattern_mdl[i] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Stopped: ticks do nothing, table loads at the field extremes
        push_req(lps_pkg::CMD_TICK, '0, '0);
        push_req(lps_pkg::CMD_WRITE, 6'd0, 8'hFF);
        push_req(lps_pkg::CMD_WRITE, 6'd63, 8'h00);
        push_req(lps_pkg::CMD_WRITE, 6'd1, 8'hA5);
        push_req(lps_pkg::CMD_WRITE, 6'd62, 8'h5A);
        push_req(lps_pkg::CMD_TICK, 6'h3F, 8'hFF);
        settle();

        // Zero divider: every running tick emits; a write in between is no tick
        cfg_write(lps_pkg::CFG_RUN, 8'd1);
        cfg_write(lps_pkg::CFG_REPEAT, 8'd0);
        cfg_write(lps_pkg::CFG_DIVIDER, 8'd0);
        @(negedge clk);
        repeat (3) push_req(lps_pkg::CMD_TICK, '0, '0);
        push_req(lps_pkg::CMD_WRITE, 6'd3, 8'h3C);
        repeat (2) push_req(lps_pkg::CMD_TICK, '0, '0);
        settle();

        // Divider of two: one emit per three ticks
        cfg_write(lps_pkg::CFG_DIVIDER, 8'd2);
        @(negedge clk);
        repeat (8) push_req(lps_pkg::CMD_TICK, '0, '0);
        settle();

        // Random phases; the first ones run off the end, then wrap, then max divider
        for (int ph = 0; n_pushed < ITEM_TARGET; ph++)
        begin
            len      = $urandom_range(40, 140);
            tick_pct = $urandom_range(50, 90);
            burst    = ($urandom_range(0, 3) == 0);
            case (ph)
                0:
                begin
                    run_v = 1'b1; rep_v = 1'b0; div_v = 8'd0; len = 80; tick_pct = 100;
                end
                1:
                begin
                    run_v = 1'b1; rep_v = 1'b1; div_v = 8'd0; len = 80; tick_pct = 100;
                end
                2:
                begin
                    run_v = 1'b1; rep_v = 1'b1; div_v = 8'd255; len = 300; tick_pct = 100;
                end
                default:
                begin
                    run_v = ($urandom_range(0, 4) != 0);
                    rep_v = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 7))
                        0, 1, 2, 3: div_v = 8'd0;
                        4, 5:       div_v = 8'($urandom_range(1, 3));
                        6:          div_v = 8'd255;
                        default:    div_v = 8'($urandom_range(0, 255));
                    endcase
                end
            endcase
            cfg_write(lps_pkg::CFG_RUN, {7'($urandom), run_v});
            cfg_write(lps_pkg::CFG_REPEAT, {7'($urandom), rep_v});
            cfg_write(lps_pkg::CFG_DIVIDER, div_v);
            @(negedge clk);
            repeat (len)
            begin
                if ($urandom_range(1, 100) <= tick_pct)
                    push_req(lps_pkg::CMD_TICK, 6'($urandom), 8'($urandom));
                else
                    push_req(lps_pkg::CMD_WRITE, 6'($urandom_range(0, 63)), 8'($urandom));
            end
            settle();
        end

        if (err_count == 0 && led_expect_q.size() == 0)
            $display("led_pattern_sequencer_core regression: pass");
        else
            $display("led_pattern_sequencer_core regression: fail");
        $finish;
    end

endmodule
